FILE: hw/rtl/byte_stream_pattern_patcher_defines.svh
// ----------------------------------------------------------------------------
// Byte stream pattern patcher: assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BYTE_STREAM_PATTERN_PATCHER_DEFINES_SVH
`define BYTE_STREAM_PATTERN_PATCHER_DEFINES_SVH

// consequent checked in the same cycle
`define BSPP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the next cycle
`define BSPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bspp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspp_pkg
// Types and constants shared by the byte stream pattern patcher modules.
// ----------------------------------------------------------------------------
package bspp_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_OLD_POS   = 3'd0,
    REG_NEW_POS   = 3'd1,
    REG_EN_BASE   = 3'd2,
    REG_EN_166    = 3'd3,
    REG_EN_150    = 3'd4,
    REG_EN_UNPROT = 3'd5,
    REG_WRITE_EN  = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    POS_NONE = 2'd0,
    POS_BASE = 2'd1,
    POS_166  = 2'd2,
    POS_150  = 2'd3
  } pos_code_t;

  localparam logic [1:0]  FILL_FULL   = 2'd3;

  localparam logic [31:0] OLD_POS_RST = 32'h0000_afc8;
  localparam logic [31:0] NEW_POS_RST = 32'h0000_2db6;
  localparam logic [31:0] OFFSET_A    = 32'd166;
  localparam logic [31:0] OFFSET_B    = 32'd150;

  // fixed pattern, in stream order
  localparam logic [7:0]  PAT_B0  = 8'hCD;
  localparam logic [7:0]  PAT_B1  = 8'hE4;
  localparam logic [7:0]  PAT_B2  = 8'h43;
  localparam logic [7:0]  PAT_B3  = 8'h6A;
  localparam logic [7:0]  REPL_B0 = 8'h09;
  localparam logic [7:0]  REPL_B1 = 8'h00;
  localparam logic [7:0]  REPL_B2 = 8'h09;
  localparam logic [7:0]  REPL_B3 = 8'h00;

  typedef struct packed {
    logic [31:0] old_pos;
    logic [31:0] old_p166;
    logic [31:0] old_p150;
    logic [31:0] new_pos;
    logic [31:0] new_p166;
    logic [31:0] new_p150;
    logic        en_any;
    logic        en_166;
    logic        en_150;
    logic        en_unprot;
    logic        wr_en;
  } cfg_t;

  // stage one to stage two
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       uhit;
    logic       patch;
  } s2_item_t;

  // stage two result
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       uhit;
    pos_code_t  code;
    logic       patch;
  } s2_res_t;

  // item held in the output buffer
  typedef struct packed {
    logic [7:0] data;
    logic       uhit;
    pos_code_t  code;
    logic       patched;
    logic       last;
  } out_item_t;

endpackage

FILE: hw/rtl/bspp_stage1.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspp_stage1
// Fixed pattern window: holds three bytes, matches CD E4 43 6A against the
// held bytes plus the incoming one and optionally replaces the window.
// ----------------------------------------------------------------------------
module bspp_stage1 (
  input  logic               clk,
  input  logic               rst_n,
  input  bspp_pkg::cfg_t     cfg,
  input  logic               load,
  input  logic               pop,
  input  logic [7:0]         byte_i,
  output logic [1:0]         fill_o,
  output bspp_pkg::s2_item_t item_o
);

  logic [7:0] win_r [0:2];
  logic [7:0] win_nxt [0:2];
  logic [1:0] fill_r, fill_nxt;
  logic       full;
  logic       hit;
  logic       patch;

  always_comb begin
    full  = (fill_r == bspp_pkg::FILL_FULL);
    hit   = cfg.en_unprot &&
            (win_r[0] == bspp_pkg::PAT_B0) && (win_r[1] == bspp_pkg::PAT_B1) &&
            (win_r[2] == bspp_pkg::PAT_B2) && (byte_i == bspp_pkg::PAT_B3);
    patch = load && full && hit && cfg.wr_en;

    item_o.vld   = (load && full) || pop;
    item_o.data  = patch ? bspp_pkg::REPL_B0 : win_r[0];
    item_o.uhit  = load && full && hit;
    item_o.patch = patch;
  end

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    if (load) begin
      if (!full) begin
        win_nxt[fill_r] = byte_i;
        fill_nxt        = fill_r + 2'd1;
      end else if (patch) begin
        win_nxt[0] = bspp_pkg::REPL_B1;
        win_nxt[1] = bspp_pkg::REPL_B2;
        win_nxt[2] = bspp_pkg::REPL_B3;
      end else begin
        win_nxt[0] = win_r[1];
        win_nxt[1] = win_r[2];
        win_nxt[2] = byte_i;
      end
    end else if (pop) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      fill_nxt   = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign fill_o = fill_r;

endmodule

FILE: hw/rtl/bspp_stage2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspp_stage2
// Position window: reads the held bytes plus the incoming one as a
// little-endian word, compares with the three search values and
// optionally writes the replacement value back into the window.
// ----------------------------------------------------------------------------
module bspp_stage2 (
  input  logic               clk,
  input  logic               rst_n,
  input  bspp_pkg::cfg_t     cfg,
  input  bspp_pkg::s2_item_t item_i,
  input  logic               pop,
  output logic [1:0]         fill_o,
  output bspp_pkg::s2_res_t  res_o
);

  logic [7:0]          win_r [0:2];
  logic [7:0]          win_nxt [0:2];
  logic [2:0]          tag_r, tag_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic                full;
  logic                cmp;
  logic [31:0]         word;
  logic [31:0]         repl;
  bspp_pkg::pos_code_t code;
  logic                patch;

  always_comb begin
    full = (fill_r == bspp_pkg::FILL_FULL);
    cmp  = item_i.vld && full;
    word = {item_i.data, win_r[2], win_r[1], win_r[0]};
    code = bspp_pkg::POS_NONE;
    if (cfg.en_any) begin
      if (word == cfg.old_pos) begin
        code = bspp_pkg::POS_BASE;
      end else if (cfg.en_166 && (word == cfg.old_p166)) begin
        code = bspp_pkg::POS_166;
      end else if (cfg.en_150 && (word == cfg.old_p150)) begin
        code = bspp_pkg::POS_150;
      end
    end
    unique case (code)
      bspp_pkg::POS_BASE: repl = cfg.new_pos;
      bspp_pkg::POS_166:  repl = cfg.new_p166;
      bspp_pkg::POS_150:  repl = cfg.new_p150;
      default:            repl = word;
    endcase
    patch = cmp && (code != bspp_pkg::POS_NONE) && cfg.wr_en;

    res_o.vld   = cmp || pop;
    res_o.data  = patch ? repl[7:0] : win_r[0];
    res_o.uhit  = tag_r[0];
    res_o.code  = cmp ? code : bspp_pkg::POS_NONE;
    res_o.patch = patch;
  end

  always_comb begin
    win_nxt  = win_r;
    tag_nxt  = tag_r;
    fill_nxt = fill_r;
    if (item_i.vld) begin
      if (!full) begin
        win_nxt[fill_r] = item_i.data;
        tag_nxt[fill_r] = item_i.uhit;
        fill_nxt        = fill_r + 2'd1;
      end else begin
        if (patch) begin
          win_nxt[0] = repl[15:8];
          win_nxt[1] = repl[23:16];
          win_nxt[2] = repl[31:24];
        end else begin
          win_nxt[0] = win_r[1];
          win_nxt[1] = win_r[2];
          win_nxt[2] = item_i.data;
        end
        tag_nxt = {item_i.uhit, tag_r[2:1]};
      end
    end else if (pop) begin
      win_nxt[0] = win_r[1];
      win_nxt[1] = win_r[2];
      tag_nxt    = {1'b0, tag_r[2:1]};
      fill_nxt   = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    tag_r <= tag_nxt;
  end

  assign fill_o = fill_r;

endmodule

FILE: hw/rtl/bspp_outbuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspp_outbuf
// Output register with one skid entry, so the upstream side never waits
// combinationally on out_ready.
// ----------------------------------------------------------------------------
module bspp_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bspp_pkg::out_item_t item_i,
  input  logic                out_ready,
  output logic                out_valid,
  output bspp_pkg::out_item_t item_o,
  output logic                free_o
);

  bspp_pkg::out_item_t out_r, out_nxt;
  bspp_pkg::out_item_t skid_r, skid_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic                skid_vld_r, skid_vld_nxt;
  logic                fire;

  always_comb begin
    fire         = out_vld_r && out_ready;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (fire) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !out_ready) begin
        skid_nxt     = item_i;
        skid_vld_nxt = 1'b1;
      end else begin
        out_nxt     = item_i;
        out_vld_nxt = 1'b1;
      end
    end else if (fire) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_vld_r;
  assign item_o    = out_r;
  assign free_o    = !skid_vld_r;

endmodule

FILE: hw/rtl/byte_stream_pattern_patcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_pattern_patcher
// Two cascaded four-byte window stages over a byte stream: a fixed pattern
// patch followed by a 32-bit position value patch.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_byte_in, in_last_in
//   out      out_valid / out_ready  out_byte_out, out_unprotect_hit,
//                                   out_position_hit, out_any_patched,
//                                   out_last_out
//   cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle while the skid entry is free; a byte enters the output
// buffer at the edge that accepts the sixth byte after it (three held per
// window). After a last item the held bytes (one to six) drain at one step
// per cycle, skid permitting, with in_ready low, up to seven results in all.
// in_ready depends only on the drain flag and the skid entry of the output
// buffer. Reset is synchronous, active low, and empties windows and buffer.
// ----------------------------------------------------------------------------
`include "byte_stream_pattern_patcher_defines.svh"

module byte_stream_pattern_patcher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_out,
  output logic        out_unprotect_hit,
  output logic [1:0]  out_position_hit,
  output logic        out_any_patched,
  output logic        out_last_out,
  input  logic        cfg_we,
  input  logic [bspp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bspp_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [31:0] old_pos_r, old_p166_r, old_p150_r;
  logic [31:0] new_pos_r, new_p166_r, new_p150_r;
  logic        en_base_r, en_166_r, en_150_r, en_unprot_r, wr_en_r;
  logic        patched_r, patched_nxt;
  logic        draining_r, draining_nxt;

  bspp_pkg::cfg_t      cfg;
  bspp_pkg::s2_item_t  s1_item;
  bspp_pkg::s2_res_t   s2_res;
  bspp_pkg::out_item_t push_item;
  bspp_pkg::out_item_t out_item;
  logic [1:0]          fill1, fill2;
  logic                buf_free;
  logic                load, drain_step, pop1, pop2, last_res, any_p;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_pos_r   <= bspp_pkg::OLD_POS_RST;
      old_p166_r  <= bspp_pkg::OLD_POS_RST + bspp_pkg::OFFSET_A;
      old_p150_r  <= bspp_pkg::OLD_POS_RST + bspp_pkg::OFFSET_B;
      new_pos_r   <= bspp_pkg::NEW_POS_RST;
      new_p166_r  <= bspp_pkg::NEW_POS_RST + bspp_pkg::OFFSET_A;
      new_p150_r  <= bspp_pkg::NEW_POS_RST + bspp_pkg::OFFSET_B;
      en_base_r   <= 1'b0;
      en_166_r    <= 1'b0;
      en_150_r    <= 1'b0;
      en_unprot_r <= 1'b0;
      wr_en_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (bspp_pkg::cfg_reg_t'(cfg_index))
        bspp_pkg::REG_OLD_POS: begin
          old_pos_r  <= cfg_data;
          old_p166_r <= cfg_data + bspp_pkg::OFFSET_A;
          old_p150_r <= cfg_data + bspp_pkg::OFFSET_B;
        end
        bspp_pkg::REG_NEW_POS: begin
          new_pos_r  <= cfg_data;
          new_p166_r <= cfg_data + bspp_pkg::OFFSET_A;
          new_p150_r <= cfg_data + bspp_pkg::OFFSET_B;
        end
        bspp_pkg::REG_EN_BASE:   en_base_r   <= cfg_data[0];
        bspp_pkg::REG_EN_166:    en_166_r    <= cfg_data[0];
        bspp_pkg::REG_EN_150:    en_150_r    <= cfg_data[0];
        bspp_pkg::REG_EN_UNPROT: en_unprot_r <= cfg_data[0];
        bspp_pkg::REG_WRITE_EN:  wr_en_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.old_pos   = old_pos_r;
    cfg.old_p166  = old_p166_r;
    cfg.old_p150  = old_p150_r;
    cfg.new_pos   = new_pos_r;
    cfg.new_p166  = new_p166_r;
    cfg.new_p150  = new_p150_r;
    cfg.en_any    = en_base_r | en_166_r | en_150_r;
    cfg.en_166    = en_166_r;
    cfg.en_150    = en_150_r;
    cfg.en_unprot = en_unprot_r;
    cfg.wr_en     = wr_en_r;
  end

  // step control: one accepted item or drain step per cycle, skid permitting
  always_comb begin
    in_ready   = !draining_r && buf_free;
    load       = in_valid && in_ready;
    drain_step = draining_r && buf_free;
    pop1       = drain_step && (fill1 != 2'd0);
    pop2       = drain_step && (fill1 == 2'd0);
    last_res   = pop2 && (fill2 == 2'd1);
    any_p      = patched_r | s1_item.patch | s2_res.patch;

    draining_nxt = draining_r;
    if (load && in_last_in) begin
      draining_nxt = 1'b1;
    end else if (last_res) begin
      draining_nxt = 1'b0;
    end
    patched_nxt = last_res ? 1'b0 : any_p;

    push_item.data    = s2_res.data;
    push_item.uhit    = s2_res.uhit;
    push_item.code    = s2_res.code;
    push_item.patched = any_p;
    push_item.last    = last_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patched_r  <= 1'b0;
      draining_r <= 1'b0;
    end else begin
      patched_r  <= patched_nxt;
      draining_r <= draining_nxt;
    end
  end

  bspp_stage1 u_stage1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .load   (load),
    .pop    (pop1),
    .byte_i (in_byte_in),
    .fill_o (fill1),
    .item_o (s1_item)
  );

  bspp_stage2 u_stage2 (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .item_i (s1_item),
    .pop    (pop2),
    .fill_o (fill2),
    .res_o  (s2_res)
  );

  bspp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_res.vld),
    .item_i    (push_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .item_o    (out_item),
    .free_o    (buf_free)
  );

  assign out_byte_out      = out_item.data;
  assign out_unprotect_hit = out_item.uhit;
  assign out_position_hit  = out_item.code;
  assign out_any_patched   = out_item.patched;
  assign out_last_out      = out_item.last;

  `BSPP_ASSERT_NEXT(a_last_starts_drain, load && in_last_in, draining_r,
                    "last item did not start drain")
  `BSPP_ASSERT_SAME(a_drain_has_bytes, draining_r, (fill1 != 2'd0) || (fill2 != 2'd0),
                    "drain with empty windows")
  `BSPP_ASSERT_SAME(a_stream_out_full, s2_res.vld && !draining_r,
                    fill2 == bspp_pkg::FILL_FULL, "output from unfilled window")
  `BSPP_ASSERT_NEXT(a_end_clears, last_res, !draining_r && !patched_r,
                    "stream end did not clear state")

endmodule
